// ===== rtl/core/iir3d_pkg.sv =====
// Shared constants, register codes and types for the three-delay IIR filter.
package iir3d_pkg;

    // Coefficient format: signed Q1.14 in a 16-bit register.
    localparam int COEF_WIDTH         = 16;
    localparam int NUM_COEFS          = 5;
    localparam int CFG_INDEX_WIDTH    = 3;

    // Defaults for the top-level parameters.
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Register index codes on the configuration port.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_COEF_X0 = 3'd0,
        CFG_COEF_X1 = 3'd1,
        CFG_COEF_X2 = 3'd2,
        CFG_COEF_X3 = 3'd3,
        CFG_COEF_Y2 = 3'd4
    } cfg_index_t;

    // Coefficient values after reset.
    localparam logic signed [COEF_WIDTH-1:0] COEF_X0_RESET = 16'sd2731;
    localparam logic signed [COEF_WIDTH-1:0] COEF_X1_RESET = -16'sd8192;
    localparam logic signed [COEF_WIDTH-1:0] COEF_X2_RESET = 16'sd8192;
    localparam logic signed [COEF_WIDTH-1:0] COEF_X3_RESET = -16'sd2731;
    localparam logic signed [COEF_WIDTH-1:0] COEF_Y2_RESET = -16'sd5461;

    // The full coefficient set as seen by the datapath.
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] x0;
        logic signed [COEF_WIDTH-1:0] x1;
        logic signed [COEF_WIDTH-1:0] x2;
        logic signed [COEF_WIDTH-1:0] x3;
        logic signed [COEF_WIDTH-1:0] y2;
    } coefs_t;

endpackage

// ===== rtl/core/iir3d_sample_if.sv =====
// Valid/ready stream interface that carries one signed sample per item.
interface iir3d_sample_if #(
    parameter int WIDTH = iir3d_pkg::SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] sample;

    modport source (
        output valid,
        output sample,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample,
        output ready
    );
endinterface

// ===== rtl/core/iir3d_coef_regs.sv =====
// Coefficient register file written through the plain configuration port.
module iir3d_coef_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [iir3d_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [iir3d_pkg::COEF_WIDTH-1:0]      cfg_data,
    output iir3d_pkg::coefs_t                     coefs
);
    import iir3d_pkg::*;

    coefs_t coefs_reg;
    coefs_t coefs_next;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEF_X0: coefs_next.x0 = signed'(cfg_data);
                CFG_COEF_X1: coefs_next.x1 = signed'(cfg_data);
                CFG_COEF_X2: coefs_next.x2 = signed'(cfg_data);
                CFG_COEF_X3: coefs_next.x3 = signed'(cfg_data);
                CFG_COEF_Y2: coefs_next.y2 = signed'(cfg_data);
                // Writes to unused indexes are dropped.
                default:     coefs_next = coefs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.x0 <= COEF_X0_RESET;
            coefs_reg.x1 <= COEF_X1_RESET;
            coefs_reg.x2 <= COEF_X2_RESET;
            coefs_reg.x3 <= COEF_X3_RESET;
            coefs_reg.y2 <= COEF_Y2_RESET;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

// ===== rtl/core/iir3d_datapath.sv =====
// Delay lines, five-tap multiply-accumulate, rounding and saturation.
module iir3d_datapath #(
    parameter int SAMPLE_WIDTH   = iir3d_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = iir3d_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic signed [SAMPLE_WIDTH-1:0] x,
    input  iir3d_pkg::coefs_t              coefs,
    output logic signed [SAMPLE_WIDTH-1:0] y
);
    import iir3d_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    // Three guard bits cover the sum of five full-scale products.
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX    =
        (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_MIN    = ~SAT_MAX;

    logic signed [SAMPLE_WIDTH-1:0] x_d1_reg, x_d2_reg, x_d3_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_d1_reg, y_d2_reg;

    logic signed [PROD_W-1:0] prod_x0, prod_x1, prod_x2, prod_x3, prod_y2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rounded;

    always_comb
    begin
        prod_x0 = coefs.x0 * x;
        prod_x1 = coefs.x1 * x_d1_reg;
        prod_x2 = coefs.x2 * x_d2_reg;
        prod_x3 = coefs.x3 * x_d3_reg;
        prod_y2 = coefs.y2 * y_d2_reg;

        acc = ACC_W'(prod_x0) + ACC_W'(prod_x1) + ACC_W'(prod_x2)
            + ACC_W'(prod_x3) + ACC_W'(prod_y2);

        // Round half up, then drop the fraction bits.
        rounded = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;

        if (rounded > SAT_MAX)
            y = SAT_MAX[SAMPLE_WIDTH-1:0];
        else if (rounded < SAT_MIN)
            y = SAT_MIN[SAMPLE_WIDTH-1:0];
        else
            y = rounded[SAMPLE_WIDTH-1:0];
    end

    // The saturated output is what enters the feedback line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_d1_reg <= '0;
            x_d2_reg <= '0;
            x_d3_reg <= '0;
            y_d1_reg <= '0;
            y_d2_reg <= '0;
        end
        else if (step)
        begin
            x_d1_reg <= x;
            x_d2_reg <= x_d1_reg;
            x_d3_reg <= x_d2_reg;
            y_d1_reg <= y;
            y_d2_reg <= y_d1_reg;
        end
    end

endmodule

// ===== rtl/core/iir_filter_three_delay_core.sv =====
// Top level of the three-delay direct form 1 IIR filter core.
//
// The core computes y[n] = c0*x[n] + c1*x[n-1] + c2*x[n-2] + c3*x[n-3]
// + c4*y[n-2] on a stream of signed samples, with the five coefficients in
// signed Q1.14 registers written through the configuration port (index 0 to
// 4 selects coef_x0, coef_x1, coef_x2, coef_x3 and coef_y2; other indexes are
// ignored). Products are summed at full precision, rounded half up by
// COEF_FRAC_BITS fraction bits and saturated to SAMPLE_WIDTH bits; the
// saturated value also feeds the output delay line. Every input item yields
// exactly one result item. The core sustains one item per clock cycle while
// the output side is not stalled: an accepted sample sits in an input
// register, goes through the multiply-accumulate, rounding and saturation
// logic in a single pass, and lands in the output register, from which the
// result is offered until it is taken. The throughput is set by that single
// pass of five parallel multipliers and one adder tree. The output register
// lets a new item be accepted while a finished result still waits to be
// taken. Coefficients should only be changed while no items are in flight.
// All delay lines clear on reset and the coefficients return to their
// default values.
module iir_filter_three_delay_core #(
    parameter int SAMPLE_WIDTH   = iir3d_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = iir3d_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [iir3d_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [iir3d_pkg::COEF_WIDTH-1:0]      cfg_data,
    iir3d_sample_if.sink                          sample_in,
    iir3d_sample_if.source                        sample_out
);
    import iir3d_pkg::*;

    coefs_t coefs;

    // Input stage: holds the accepted sample until the datapath consumes it.
    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;

    // Output stage: holds a finished result until the sink takes it.
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;

    logic                           in_fire;
    logic                           advance;
    logic signed [SAMPLE_WIDTH-1:0] y_comb;

    iir3d_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    iir3d_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .x     (x_reg),
        .coefs (coefs),
        .y     (y_comb)
    );

    // The held sample moves on whenever the output register is empty or is
    // being emptied in this cycle; the input register then frees up at once.
    assign advance         = in_valid_reg && (!out_valid_reg || sample_out.ready);
    assign sample_in.ready = !in_valid_reg || advance;
    assign in_fire         = sample_in.valid && sample_in.ready;

    always_comb
    begin
        in_valid_next  = in_fire || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !sample_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            x_reg <= sample_in.sample;
        if (advance)
            y_reg <= y_comb;
    end

    assign sample_out.valid  = out_valid_reg;
    assign sample_out.sample = y_reg;

    // A new item must never land on a held sample that is not moving on.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_fire && in_valid_reg && !advance))
        else $error("input item overwrote a held sample");

    // An accepted item is always waiting in the input register next cycle.
    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_valid_reg)
        else $error("accepted item was lost");

    // A sample handed to the datapath always shows up as a result.
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("computed result was lost");

    // A blocked sample keeps its value until the datapath takes it.
    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(x_reg)))
        else $error("blocked sample changed");

endmodule

// ===== tb/sv/iir_filter_three_delay_core_tb.sv =====
// Self-checking testbench for the three-delay IIR filter core.
`timescale 1ns / 100ps

module iir_filter_three_delay_core_tb;

    import iir3d_pkg::*;

    localparam int SW   = SAMPLE_WIDTH_DEF;
    localparam int FRAC = COEF_FRAC_BITS_DEF;

    // Bounds that the filter output saturates to.
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    // Register indexes above the last coefficient are decoded by nobody.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = CFG_INDEX_WIDTH'(NUM_COEFS);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = '1;

    // Idle percentages of the sender and of the receiver, one pair per run phase.
    localparam int NUM_IDLE_MODES           = 3;
    localparam int SEND_IDLE [NUM_IDLE_MODES] = '{19, 81, 0};
    localparam int RECV_IDLE [NUM_IDLE_MODES] = '{81, 19, 0};

    localparam int SETS_PER_MODE = 3;
    localparam int ITEMS_PER_SET = 125;
    localparam int LONG_STALL    = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    // How the coefficient set of one random phase is chosen.
    typedef enum int {
        GAINS_RANDOM,
        GAINS_EXTREME,
        GAINS_DEFAULT
    } gain_mix_t;

    // One line of the directed script: a coefficient write or one sample.
    typedef enum logic {
        ROW_COEF,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct {
        row_kind_t                    kind;
        logic [CFG_INDEX_WIDTH-1:0]   index;
        logic signed [SW-1:0]         value;
        bit                           pinned;
        logic signed [SW-1:0]         result;
    } script_row_t;

    // A result typed into the script travels with its item until acceptance.
    typedef struct {
        bit                   pinned;
        logic signed [SW-1:0] result;
    } pinned_result_t;

    localparam int SCRIPT_LEN = 34;

    // The first rows run on the reset coefficients with cleared delay lines, so
    // silence must come out as silence. Next, a pure unit gain on x[n] passes
    // samples through unchanged, which covers both extremes and every bit of the
    // sample. Writes to the unused indexes go in between and must leave the
    // gains alone. A gain of -2.0 drives the output into both saturation bounds.
    // A gain of 0.5 on odd samples lands exactly on half steps and shows that ties
    // round toward plus infinity. The last rows put the large gains on the
    // feedback and the delayed inputs, left to the predictor.
    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h0000, 1'b1, 16'h0000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h0000, 1'b1, 16'h0000},
        '{ROW_COEF,   CFG_COEF_X0,  16'h4000, 1'b0, 16'h0000},
        '{ROW_COEF,   CFG_COEF_X1,  16'h0000, 1'b0, 16'h0000},
        '{ROW_COEF,   CFG_COEF_X2,  16'h0000, 1'b0, 16'h0000},
        '{ROW_COEF,   CFG_COEF_X3,  16'h0000, 1'b0, 16'h0000},
        '{ROW_COEF,   CFG_COEF_Y2,  16'h0000, 1'b0, 16'h0000},
        '{ROW_COEF,   CFG_SPARE_LO, 16'h7fff, 1'b0, 16'h0000},
        '{ROW_COEF,   CFG_SPARE_HI, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h7fff, 1'b1, 16'h7fff},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h8000, 1'b1, 16'h8000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h0001, 1'b1, 16'h0001},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'hffff, 1'b1, 16'hffff},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h5555, 1'b1, 16'h5555},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'haaaa, 1'b1, 16'haaaa},
        '{ROW_COEF,   CFG_COEF_X0,  16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h8000, 1'b1, 16'h7fff},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h7fff, 1'b1, 16'h8000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h0001, 1'b1, 16'hfffe},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'hffff, 1'b1, 16'h0002},
        '{ROW_COEF,   CFG_COEF_X0,  16'h2000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h0001, 1'b1, 16'h0001},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'hffff, 1'b1, 16'h0000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h0003, 1'b1, 16'h0002},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'hfffd, 1'b1, 16'hffff},
        '{ROW_COEF,   CFG_COEF_X0,  16'h4000, 1'b0, 16'h0000},
        '{ROW_COEF,   CFG_COEF_Y2,  16'h7fff, 1'b0, 16'h0000},
        '{ROW_COEF,   CFG_COEF_X3,  16'h8000, 1'b0, 16'h0000},
        '{ROW_COEF,   CFG_COEF_X1,  16'h7fff, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h7fff, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h7fff, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h7fff, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_COEF_X0,  16'h0000, 1'b0, 16'h0000}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [COEF_WIDTH-1:0]      cfg_data;

    iir3d_sample_if #(.WIDTH(SW)) in_if ();
    iir3d_sample_if #(.WIDTH(SW)) out_if ();

    iir_filter_three_delay_core #(
        .SAMPLE_WIDTH   (SW),
        .COEF_FRAC_BITS (FRAC)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (in_if.sink),
        .sample_out (out_if.source)
    );

    // Filter state as the testbench sees it: the gains and both delay lines.
    coefs_t               gains;
    logic signed [SW-1:0] x_hist1, x_hist2, x_hist3;
    logic signed [SW-1:0] y_hist1, y_hist2;

    // Filtered samples still owed by the core, oldest first.
    logic signed [SW-1:0] filtered_due [$];
    pinned_result_t       offered_pins [$];

    int send_idle_pct   = SEND_IDLE[0];
    int recv_idle_pct   = RECV_IDLE[0];
    int long_stall_left = 0;
    int fail_count      = 0;
    int cycle_count     = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Runs one sample through the filter equation and shifts both delay lines.
    // The sum is exact in 64 bits; adding half an LSB and shifting right
    // arithmetically rounds half up, then the result is clamped to the sample
    // range before it enters the output delay line.
    function automatic logic signed [SW-1:0] next_filtered(input logic signed [SW-1:0] x);
        longint acc;
        longint y;
        acc = longint'(gains.x0) * longint'(x)
            + longint'(gains.x1) * longint'(x_hist1)
            + longint'(gains.x2) * longint'(x_hist2)
            + longint'(gains.x3) * longint'(x_hist3)
            + longint'(gains.y2) * longint'(y_hist2);
        acc = acc + (longint'(1) <<< (FRAC - 1));
        y   = acc >>> FRAC;
        if (y > SAMPLE_MAX)
            y = SAMPLE_MAX;
        else if (y < SAMPLE_MIN)
            y = SAMPLE_MIN;
        x_hist3 = x_hist2;
        x_hist2 = x_hist1;
        x_hist1 = x;
        y_hist2 = y_hist1;
        y_hist1 = y[SW-1:0];
        return y[SW-1:0];
    endfunction

    // Mirrors a register write in the testbench's copy of the gains.
    function automatic void apply_gain(input logic [CFG_INDEX_WIDTH-1:0] index,
                                       input logic [COEF_WIDTH-1:0] value);
        case (index)
            CFG_COEF_X0: gains.x0 = value;
            CFG_COEF_X1: gains.x1 = value;
            CFG_COEF_X2: gains.x2 = value;
            CFG_COEF_X3: gains.x3 = value;
            CFG_COEF_Y2: gains.y2 = value;
            default: ;
        endcase
    endfunction

    // Mostly full-range samples, with the extremes and small values mixed in.
    function automatic logic signed [SW-1:0] pick_sample();
        logic signed [SW-1:0] s;
        case ($urandom_range(9))
            0:       s = SW'(SAMPLE_MAX);
            1:       s = SW'(SAMPLE_MIN);
            2, 3:    s = SW'(int'($urandom_range(255)) - 128);
            default: s = SW'($urandom);
        endcase
        return s;
    endfunction

    // A write holds the enable for one cycle and then drops it before it returns,
    // so that back-to-back writes never raise and lower it within one time step.
    // Called right after a falling edge, returns right after a falling edge.
    task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [COEF_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        apply_gain(index, value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one item after a random number of idle cycles and returns right
    // after the falling edge that follows its acceptance. Garbage sits on the
    // sample lines while valid is low.
    task automatic push_sample(input logic signed [SW-1:0] value, input bit pinned,
                               input logic signed [SW-1:0] result);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid  <= 1'b0;
            in_if.sample <= SW'($urandom);
            @(negedge clk);
        end
        offered_pins.push_back('{pinned, result});
        in_if.valid  <= 1'b1;
        in_if.sample <= value;
        do
            @(posedge clk);
        while (!in_if.ready);
        @(negedge clk);
    endtask

    // Stops offering items and waits until every filtered sample is back, plus
    // a settling wait for the two-stage pipeline to go quiet, so that the gains
    // can be changed safely.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (filtered_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes all five gains plus one unused index with junk.
    task automatic load_gains(input gain_mix_t mix);
        logic [COEF_WIDTH-1:0] v [NUM_COEFS];
        case (mix)
            GAINS_RANDOM:
                foreach (v[i]) v[i] = COEF_WIDTH'($urandom);
            GAINS_EXTREME:
                foreach (v[i]) v[i] = $urandom_range(1) ? 16'h7fff : 16'h8000;
            default:
                v = '{COEF_X0_RESET, COEF_X1_RESET, COEF_X2_RESET,
                      COEF_X3_RESET, COEF_Y2_RESET};
        endcase
        cfg_write(CFG_COEF_X0, v[0]);
        cfg_write(CFG_COEF_X1, v[1]);
        cfg_write(CFG_COEF_X2, v[2]);
        cfg_write(CFG_COEF_X3, v[3]);
        cfg_write(CFG_COEF_Y2, v[4]);
        cfg_write(CFG_INDEX_WIDTH'($urandom_range(NUM_COEFS, int'(CFG_SPARE_HI))),
                  COEF_WIDTH'($urandom));
    endtask

    // Receiver: ready is redrawn every falling edge. A long hold-off requested
    // by the stimulus is counted down here, one cycle per edge.
    initial begin
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (long_stall_left > 0) begin
                long_stall_left--;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Scoreboard. Each rising edge first checks an accepted result against the
    // oldest filtered sample still owed, then predicts the result of an item
    // accepted at the same edge. A result typed into the script takes the
    // place of the prediction, while the prediction still advances the delay
    // lines.
    always @(posedge clk) begin : scoreboard
        pinned_result_t       pin;
        logic signed [SW-1:0] due;
        if (rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (filtered_due.size() == 0) begin
                    $display("%0t: unexpected sample_out %0d, expected none",
                             $time, out_if.sample);
                    fail_count++;
                end
                else begin
                    due = filtered_due.pop_front();
                    if (out_if.sample !== due) begin
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, due, out_if.sample);
                        fail_count++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                pin = offered_pins.pop_front();
                due = next_filtered(in_if.sample);
                filtered_due.push_back(pin.pinned ? pin.result : due);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Main stimulus: reset, the directed script, then three idling regimes with
    // three coefficient sets each.
    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_if.valid  = 1'b0;
        in_if.sample = '0;
        gains        = '{COEF_X0_RESET, COEF_X1_RESET, COEF_X2_RESET,
                         COEF_X3_RESET, COEF_Y2_RESET};
        x_hist1      = '0;
        x_hist2      = '0;
        x_hist3      = '0;
        y_hist1      = '0;
        y_hist2      = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[r]) begin
            if (script[r].kind == ROW_COEF) begin
                settle();
                cfg_write(script[r].index, script[r].value);
            end
            else
                push_sample(script[r].value, script[r].pinned, script[r].result);
        end

        for (int m = 0; m < NUM_IDLE_MODES; m++) begin
            send_idle_pct = SEND_IDLE[m];
            recv_idle_pct = RECV_IDLE[m];
            for (int k = 0; k < SETS_PER_MODE; k++) begin
                settle();
                load_gains(gain_mix_t'(k));
                // With the sender never idle, a long receiver hold-off fills the
                // output register and the pipeline, and the core must push back
                // on its input.
                if (m == NUM_IDLE_MODES - 1 && k == 0) begin
                    @(posedge clk);
                    long_stall_left = LONG_STALL;
                    @(negedge clk);
                end
                for (int n = 0; n < ITEMS_PER_SET; n++)
                    push_sample(pick_sample(), 1'b0, '0);
            end
        end

        settle();
        if (filtered_due.size() != 0) begin
            $display("%0t: %0d filtered samples never arrived", $time, filtered_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
